// File: design/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, constants and the arctangent table for the sphere evaluator.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int ANGLE_BITS  = 32;
   localparam int TRIG_STAGES = 24;
   localparam int CW          = 34;   // CORDIC datapath width
   localparam int QDEPTH      = 4;
   localparam int QAW         = $clog2(QDEPTH);
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_RADIUS   = 3'd3;
   localparam logic [2:0] REG_X_AXIS   = 3'd4;
   localparam logic [2:0] REG_Y_AXIS   = 3'd5;
   localparam logic [2:0] REG_Z_AXIS   = 3'd6;

   typedef struct packed {
      logic [31:0] angle_u;
      logic [31:0] angle_v;
      logic [3:0]  order_u;
      logic [3:0]  order_v;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] cu;
      logic signed [31:0] su;
      logic signed [31:0] cv;
      logic signed [31:0] sv;
      logic [3:0]         order_u;
      logic [3:0]         order_v;
   } trig_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] center_z;
      logic [30:0] radius;
      logic [47:0] x_axis;
      logic [47:0] y_axis;
      logic [47:0] z_axis;
   } cfg_type;

   function automatic logic [31:0] atan_val(input int i);
      logic [31:0] v;
      case (i)
         0: v = 32'h20000000;   1: v = 32'h12E4051E;   2: v = 32'h09FB385B;
         3: v = 32'h051111D4;   4: v = 32'h028B0D43;   5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;   7: v = 32'h00517C55;   8: v = 32'h0028BE53;
         9: v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
         15: v = 32'h0000517D; 16: v = 32'h000028BE;  17: v = 32'h0000145F;
         18: v = 32'h00000A30; 19: v = 32'h00000518;  20: v = 32'h0000028C;
         21: v = 32'h00000146; 22: v = 32'h000000A3;  23: v = 32'h00000051;
         24: v = 32'h00000029; 25: v = 32'h00000014;  26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000003;  29: v = 32'h00000001;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// File: design/sphere_surface_point_and_derivative.sv
// ----------------------------------------------------------------------------
// sphere_surface_point_and_derivative
// Sphere point / partial derivative evaluator from turn-fraction angles.
// ----------------------------------------------------------------------------
// channel   ports                         direction
// req       req_valid req_stall req       in  (angles, orders)
// rsp       rsp_valid rsp_stall rsp       out (vector, clipped)
// csr       csr_we csr_index csr_wdata    in  (register writes)
//
// One transfer per cycle sustained while rsp_stall is low; latency is set by
// the CORDIC pipeline plus queue and six back-end stages.
// Synchronous reset clears all valid bits and loads register defaults.
// rsp_stall freezes the back end; the front keeps taking transfers until
// the four-entry queue is full and an item waits at the CORDIC output.
// ----------------------------------------------------------------------------
module sphere_surface_point_and_derivative (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssd_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssd_pkg::rsp_type rsp,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [47:0]      csr_wdata
);
   import ssd_pkg::*;

   cfg_type      cfg_ff;
   logic         push, pop;
   trig_type     push_data, pop_data;
   q_status_type qs;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
         cfg_ff.center_z <= '0;
         cfg_ff.radius   <= 31'd65536;
         cfg_ff.x_axis   <= 48'd16384;
         cfg_ff.y_axis   <= 48'd16384 << 16;
         cfg_ff.z_axis   <= 48'd16384 << 32;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CENTER_X: cfg_ff.center_x <= csr_wdata[31:0];
            REG_CENTER_Y: cfg_ff.center_y <= csr_wdata[31:0];
            REG_CENTER_Z: cfg_ff.center_z <= csr_wdata[31:0];
            REG_RADIUS:   cfg_ff.radius   <= csr_wdata[30:0];
            REG_X_AXIS:   cfg_ff.x_axis   <= csr_wdata;
            REG_Y_AXIS:   cfg_ff.y_axis   <= csr_wdata;
            REG_Z_AXIS:   cfg_ff.z_axis   <= csr_wdata;
            default: ;
         endcase
      end
   end

   ssd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req,
      .push, .push_data, .q_full(qs.full)
   );

   ssd_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .status(qs)
   );

   ssd_back u_back (
      .clock, .reset, .cfg(cfg_ff), .q_empty(qs.empty), .pop, .pop_data,
      .rsp_valid, .rsp_stall, .rsp
   );

   a_q_sane: assert property (@(posedge clock) disable iff (reset)
      !(qs.full && qs.empty)) else $error("queue full and empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qs.full && !pop |-> !push) else $error("push into full queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");

   a_clip_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.clipped |->
         rsp.out_x == 32'sh7FFFFFFF || rsp.out_x == 32'sh80000000 ||
         rsp.out_y == 32'sh7FFFFFFF || rsp.out_y == 32'sh80000000 ||
         rsp.out_z == 32'sh7FFFFFFF || rsp.out_z == 32'sh80000000)
      else $error("clipped without a limit value");

endmodule

// File: design/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Angle reduction and pipelined CORDIC for both angles; quadrant fix-up.
// ----------------------------------------------------------------------------
module ssd_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ssd_pkg::req_type req,
   output logic            push,
   output ssd_pkg::trig_type push_data,
   input  logic            q_full
);
   import ssd_pkg::*;

   localparam int NS = TRIG_STAGES + 1;

   logic              vld_ff [NS];
   logic signed [CW-1:0] ux_ff [NS], uy_ff [NS], uz_ff [NS];
   logic signed [CW-1:0] vx_ff [NS], vy_ff [NS], vz_ff [NS];
   logic [1:0]        uq_ff [NS], vq_ff [NS];
   logic [3:0]        ou_ff [NS], ov_ff [NS];
   logic              en;

   logic [31:0]       keep;
   logic [31:0]       au, av;
   logic [32:0]       nu_w, nv_w;
   logic [2:0]        nu, nv;
   logic signed [CW-1:0] ru, rv;

   assign en        = !(vld_ff[NS-1] && q_full);
   assign req_stall = !en;
   assign push      = vld_ff[NS-1] && en;

   assign keep = ~32'((33'd1 << (32 - ANGLE_BITS)) - 33'd1);
   assign au   = req.angle_u & keep;
   assign av   = req.angle_v & keep;
   assign nu_w = ({1'b0, au} + 33'h020000000) >> 30;
   assign nv_w = ({1'b0, av} + 33'h020000000) >> 30;
   assign nu   = nu_w[2:0];
   assign nv   = nv_w[2:0];
   assign ru   = $signed({2'b00, au}) - $signed({1'b0, nu, 30'd0});
   assign rv   = $signed({2'b00, av}) - $signed({1'b0, nv, 30'd0});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
      end
      if (en) begin
         ux_ff[0] <= CORDIC_GAIN;
         uy_ff[0] <= '0;
         uz_ff[0] <= ru;
         vx_ff[0] <= CORDIC_GAIN;
         vy_ff[0] <= '0;
         vz_ff[0] <= rv;
         uq_ff[0] <= nu[1:0];
         vq_ff[0] <= nv[1:0];
         ou_ff[0] <= req.order_u;
         ov_ff[0] <= req.order_v;
      end
   end

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
      localparam logic signed [CW-1:0] TA = $signed({2'b00, atan_val(i)});
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (en) begin
            if (!uz_ff[i][CW-1]) begin
               ux_ff[i+1] <= ux_ff[i] - (uy_ff[i] >>> i);
               uy_ff[i+1] <= uy_ff[i] + (ux_ff[i] >>> i);
               uz_ff[i+1] <= uz_ff[i] - TA;
            end else begin
               ux_ff[i+1] <= ux_ff[i] + (uy_ff[i] >>> i);
               uy_ff[i+1] <= uy_ff[i] - (ux_ff[i] >>> i);
               uz_ff[i+1] <= uz_ff[i] + TA;
            end
            if (!vz_ff[i][CW-1]) begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - TA;
            end else begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + TA;
            end
            uq_ff[i+1] <= uq_ff[i];
            vq_ff[i+1] <= vq_ff[i];
            ou_ff[i+1] <= ou_ff[i];
            ov_ff[i+1] <= ov_ff[i];
         end
      end
   end

   logic signed [CW-1:0] cu, su, cv, sv;
   always_comb begin
      case (uq_ff[NS-1])
         2'd0: begin cu = ux_ff[NS-1];  su = uy_ff[NS-1];  end
         2'd1: begin cu = -uy_ff[NS-1]; su = ux_ff[NS-1];  end
         2'd2: begin cu = -ux_ff[NS-1]; su = -uy_ff[NS-1]; end
         default: begin cu = uy_ff[NS-1]; su = -ux_ff[NS-1]; end
      endcase
      case (vq_ff[NS-1])
         2'd0: begin cv = vx_ff[NS-1];  sv = vy_ff[NS-1];  end
         2'd1: begin cv = -vy_ff[NS-1]; sv = vx_ff[NS-1];  end
         2'd2: begin cv = -vx_ff[NS-1]; sv = -vy_ff[NS-1]; end
         default: begin cv = vy_ff[NS-1]; sv = -vx_ff[NS-1]; end
      endcase
      push_data.cu      = cu[31:0];
      push_data.su      = su[31:0];
      push_data.cv      = cv[31:0];
      push_data.sv      = sv[31:0];
      push_data.order_u = ou_ff[NS-1];
      push_data.order_v = ov_ff[NS-1];
   end

endmodule

// File: design/ssd_queue.sv
// ----------------------------------------------------------------------------
// ssd_queue
// Short FIFO between the trig front and the vector back end.
// ----------------------------------------------------------------------------
module ssd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssd_pkg::trig_type push_data,
   input  logic              pop,
   output ssd_pkg::trig_type pop_data,
   output ssd_pkg::q_status_type status
);
   import ssd_pkg::*;

   trig_type     mem_ff [QDEPTH];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0]   cnt_ff;

   assign status.full  = (cnt_ff == QDEPTH[QAW:0]);
   assign status.empty = (cnt_ff == '0);
   assign pop_data     = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

// File: design/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Axis projection, derivative phase, radius scale, center add and clamp.
// ----------------------------------------------------------------------------
module ssd_back (
   input  logic              clock,
   input  logic              reset,
   input  ssd_pkg::cfg_type  cfg,
   input  logic              q_empty,
   output logic              pop,
   input  ssd_pkg::trig_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ssd_pkg::rsp_type  rsp
);
   import ssd_pkg::*;

   logic       v_ff [6];
   logic       en;
   logic       neg_ff;
   logic       uz_ff [5];
   logic       pt_ff [5];
   logic signed [31:0] a_ff [2];

   assign en        = !(v_ff[5] && rsp_stall);
   assign pop       = !q_empty && en;
   assign rsp_valid = v_ff[5];

   // stage 1 operand select
   logic signed [31:0] t1, t2, a, zc;
   always_comb begin
      case (pop_data.order_u[0])
         1'b0: begin t1 = pop_data.cu;  t2 = pop_data.su; end
         default: begin t1 = -pop_data.su; t2 = pop_data.cu; end
      endcase
      case (pop_data.order_v[1:0])
         2'd0: begin a = pop_data.cv;  zc = pop_data.sv;  end
         2'd1: begin a = -pop_data.sv; zc = pop_data.cv;  end
         2'd2: begin a = -pop_data.cv; zc = -pop_data.sv; end
         default: begin a = pop_data.sv; zc = -pop_data.cv; end
      endcase
   end

   logic signed [47:0] px_ff [3], py_ff [3], pz_ff [3];
   logic signed [35:0] d_ff [3];
   logic signed [31:0] zt_ff [3];
   logic signed [31:0] zt2_ff [3];
   logic signed [67:0] p_ff [3];
   logic signed [36:0] w_ff [3];
   logic signed [68:0] rw_ff [3];
   logic signed [31:0] o_ff [3];
   logic       clip_ff;

   logic signed [48:0] s_rnd [3];
   logic signed [47:0] z_rnd [3];
   logic signed [67:0] p_rnd [3];
   logic signed [68:0] r_rnd [3];
   logic signed [31:0] cen [3];
   logic signed [41:0] r_sum [3];
   logic signed [31:0] r_sat [3];
   logic       r_clip [3];

   assign cen[0] = cfg.center_x;
   assign cen[1] = cfg.center_y;
   assign cen[2] = cfg.center_z;

   for (genvar k = 0; k < 3; k++) begin : g_comp
      logic signed [15:0] xa, ya, za;
      assign xa = cfg.x_axis[16*k +: 16];
      assign ya = cfg.y_axis[16*k +: 16];
      assign za = cfg.z_axis[16*k +: 16];

      assign s_rnd[k] = 49'(px_ff[k]) + 49'(py_ff[k]) + 49'sd8192;
      assign z_rnd[k] = pz_ff[k] + 48'sd32768;
      assign p_rnd[k] = p_ff[k] + 68'sh80000000;
      assign r_rnd[k] = rw_ff[k] + 69'sh8000000;

      always_comb begin
         r_sum[k] = 42'($signed(r_rnd[k][68:28])) + (pt_ff[4] ? 42'(cen[k]) : 42'sd0);
         r_clip[k] = 1'b0;
         r_sat[k]  = r_sum[k][31:0];
         if (r_sum[k] > 42'sd2147483647) begin
            r_sat[k] = 32'sh7FFFFFFF; r_clip[k] = 1'b1;
         end else if (r_sum[k] < -42'sd2147483648) begin
            r_sat[k] = 32'sh80000000; r_clip[k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            px_ff[k]  <= t1 * xa;
            py_ff[k]  <= t2 * ya;
            pz_ff[k]  <= zc * za;
            d_ff[k]   <= neg_ff ? -36'($signed(s_rnd[k][48:14]))
                                : 36'($signed(s_rnd[k][48:14]));
            zt_ff[k]  <= z_rnd[k][47:16];
            zt2_ff[k] <= zt_ff[k];
            p_ff[k]   <= a_ff[1] * d_ff[k];
            w_ff[k]   <= 37'($signed(p_rnd[k][67:32])) +
                         (uz_ff[2] ? 37'(zt2_ff[k]) : 37'sd0);
            rw_ff[k]  <= $signed({1'b0, cfg.radius}) * w_ff[k];
            o_ff[k]   <= r_sat[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= pop;
         for (int i = 1; i < 6; i++) v_ff[i] <= v_ff[i-1];
      end
      if (en) begin
         neg_ff    <= pop_data.order_u[1];
         a_ff[0]   <= a;
         a_ff[1]   <= a_ff[0];
         uz_ff[0]  <= (pop_data.order_u == 4'd0);
         pt_ff[0]  <= (pop_data.order_u == 4'd0) && (pop_data.order_v == 4'd0);
         for (int i = 1; i < 5; i++) begin
            uz_ff[i] <= uz_ff[i-1];
            pt_ff[i] <= pt_ff[i-1];
         end
         clip_ff <= r_clip[0] | r_clip[1] | r_clip[2];
      end
   end

   assign rsp.out_x   = o_ff[0];
   assign rsp.out_y   = o_ff[1];
   assign rsp.out_z   = o_ff[2];
   assign rsp.clipped = clip_ff;

endmodule

// File: dv/sphere_eval_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_eval_checker
// Watches both channels of the sphere evaluator, predicts each vector from the
// accepted angles and orders and the current register values, and compares.
// ----------------------------------------------------------------------------
module sphere_eval_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ssd_pkg::req_type req,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ssd_pkg::rsp_type rsp,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [47:0]      csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               rsp_count,
   output int               clip_count
);
   import ssd_pkg::*;

   cfg_type          regs;
   rsp_type          vec_queue[$];

   function automatic longint rshift_round(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint axis_part(logic [47:0] p, int k);
      logic signed [15:0] c;
      c = p[16*k +: 16];
      return longint'(c);
   endfunction

   function automatic void turn_trig(input logic [31:0] ang, output longint co,
                                     output longint si);
      longint x, y, z, dx, dy;
      logic [32:0] n;
      logic [31:0] am;
      am = ang & ~32'((33'd1 << (32 - ANGLE_BITS)) - 33'd1);
      n = ({1'b0, am} + 33'h20000000) >> 30;
      x = 652032874;
      y = 0;
      z = longint'(am) - (longint'(n) <<< 30);
      for (int i = 0; i < TRIG_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_val(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_val(i));
         end
      end
      case (n[1:0])
         2'd0: begin co = x;  si = y;  end
         2'd1: begin co = -y; si = x;  end
         2'd2: begin co = -x; si = -y; end
         default: begin co = y; si = -x; end
      endcase
   endfunction

   function automatic rsp_type sphere_vector(req_type r, cfg_type c);
      longint cu, su, cv, sv, a, zc, xa, ya, za, d, w, res;
      logic [31:0] cen[3];
      logic signed [31:0] comp[3];
      rsp_type o;
      cen[0] = c.center_x; cen[1] = c.center_y; cen[2] = c.center_z;
      turn_trig(r.angle_u, cu, su);
      turn_trig(r.angle_v, cv, sv);
      case (r.order_v[1:0])
         2'd0: begin a = cv;  zc = sv;  end
         2'd1: begin a = -sv; zc = cv;  end
         2'd2: begin a = -cv; zc = -sv; end
         default: begin a = sv; zc = -cv; end
      endcase
      o.clipped = 1'b0;
      for (int k = 0; k < 3; k++) begin
         xa = axis_part(c.x_axis, k);
         ya = axis_part(c.y_axis, k);
         za = axis_part(c.z_axis, k);
         case (r.order_u[1:0])
            2'd0: d = rshift_round(cu * xa + su * ya, 14);
            2'd1: d = rshift_round(-su * xa + cu * ya, 14);
            2'd2: d = -rshift_round(cu * xa + su * ya, 14);
            default: d = -rshift_round(-su * xa + cu * ya, 14);
         endcase
         w = rshift_round(a * d, 32);
         if (r.order_u == 4'd0) w += rshift_round(zc * za, 16);
         res = rshift_round(longint'({1'b0, c.radius}) * w, 28);
         if (r.order_u == 4'd0 && r.order_v == 4'd0)
            res += longint'(signed'(cen[k]));
         if (res > 64'sd2147483647) begin
            res = 64'sd2147483647; o.clipped = 1'b1;
         end
         if (res < -64'sd2147483648) begin
            res = -64'sd2147483648; o.clipped = 1'b1;
         end
         comp[k] = res[31:0];
      end
      o.out_x = comp[0]; o.out_y = comp[1]; o.out_z = comp[2];
      return o;
   endfunction

   assign pending = vec_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         regs.center_x <= '0; regs.center_y <= '0; regs.center_z <= '0;
         regs.radius <= 31'd65536;
         regs.x_axis <= 48'd16384;
         regs.y_axis <= 48'd16384 << 16;
         regs.z_axis <= 48'd16384 << 32;
         fail_count <= 0; rsp_count <= 0; clip_count <= 0;
         vec_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CENTER_X: regs.center_x <= csr_wdata[31:0];
               REG_CENTER_Y: regs.center_y <= csr_wdata[31:0];
               REG_CENTER_Z: regs.center_z <= csr_wdata[31:0];
               REG_RADIUS:   regs.radius   <= csr_wdata[30:0];
               REG_X_AXIS:   regs.x_axis   <= csr_wdata;
               REG_Y_AXIS:   regs.y_axis   <= csr_wdata;
               REG_Z_AXIS:   regs.z_axis   <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) vec_queue.push_back(sphere_vector(req, regs));
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (rsp.clipped) clip_count <= clip_count + 1;
            if (vec_queue.size() == 0) begin
               $display("%0t unexpected transfer: actual %h", $time, rsp);
               fail_count <= fail_count + 1;
            end else begin
               want = vec_queue.pop_front();
               if (want !== rsp) begin
                  $display("%0t mismatch: expected x=%h y=%h z=%h clip=%b", $time,
                           want.out_x, want.out_y, want.out_z, want.clipped);
                  $display("%0t           actual   x=%h y=%h z=%h clip=%b", $time,
                           rsp.out_x, rsp.out_y, rsp.out_z, rsp.clipped);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: dv/sphere_surface_point_and_derivative_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_surface_point_and_derivative_tb
// Drives angle/order transfers in bursts under random and long output stalls,
// across several register settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module sphere_surface_point_and_derivative_tb;
   import ssd_pkg::*;

   localparam int LATENCY = 40;
   localparam int IDLE_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   int          fail_count, pending, rsp_count, clip_count;
   int          idle_cycles = 0;
   bit          hold_long = 1'b0;
   bit          stall_on = 1'b0;

   always #1 clock = ~clock;

   sphere_surface_point_and_derivative u_dut (.*);

   sphere_eval_checker u_checker (.*);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("timeout waiting for transfers");
         $display("status: fail");
         $finish;
      end
   end

   // receiver stall pattern: calm stretches, random stalls, one long hold-off
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 80)) begin
            @(posedge clock);
            if (hold_long) begin
               rsp_stall <= 1'b1;
               repeat (200) @(posedge clock);
               hold_long = 1'b0;
               rsp_stall <= 1'b0;
            end else if (stall_on && mode != 0)
               rsp_stall <= ($urandom_range(0, 3) < mode);
            else rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [47:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   function automatic logic [47:0] pack_axis(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic req_type rand_item();
      req_type r;
      r.angle_u = $urandom;
      r.angle_v = $urandom;
      case ($urandom_range(0, 3))
         0: r.angle_u = {2'($urandom_range(0, 3)), 30'd0} + $urandom_range(0, 8) - 4;
         1: r.angle_v = {2'($urandom_range(0, 3)), 30'd0} + 32'h20000000
                        - $urandom_range(0, 2);
         default: ;
      endcase
      r.order_u = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      r.order_v = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      return r;
   endfunction

   task automatic random_phase(input int count);
      int left;
      left = count;
      while (left > 0) begin
         repeat ($urandom_range(1, 30)) begin
            if (left > 0) begin
               send_item(rand_item());
               left--;
            end
         end
         if ($urandom_range(0, 2) == 0) send_gap();
      end
   endtask

   initial begin
      req_type d;
      logic [31:0] edge_ang[6];
      edge_ang = '{32'h0, 32'hFFFFFFFF, 32'h20000000, 32'h1FFFFFFF, 32'h40000000,
                   32'hC0000000};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: angle extremes, every order phase, orders above three
      for (int i = 0; i < 6; i++) begin
         d.angle_u = edge_ang[i]; d.angle_v = edge_ang[5 - i];
         d.order_u = 4'(i % 4); d.order_v = 4'((i + 1) % 4);
         send_item(d);
      end
      for (int i = 0; i < 16; i++) begin
         d.angle_u = 32'h12345678 * i; d.angle_v = ~d.angle_u;
         d.order_u = 4'(i); d.order_v = 4'(15 - i);
         send_item(d);
      end
      d = '0;
      send_item(d);
      stall_on = 1'b1;
      random_phase(250);
      drain();

      // offset center, larger radius, skewed axes
      csr_write(REG_CENTER_X, 48'h0001_2345_6789);
      csr_write(REG_CENTER_Y, 48'hFFFF_8000_0000);
      csr_write(REG_CENTER_Z, 48'h0000_7FFF_FFFF);
      csr_write(REG_RADIUS, 48'd12345678);
      csr_write(REG_X_AXIS, pack_axis(11585, 11585, 0));
      csr_write(REG_Y_AXIS, pack_axis(-11585, 11585, 100));
      csr_write(3'd7, 48'hFFFF_FFFF_FFFF);
      hold_long = 1'b1;
      random_phase(300);
      drain();

      // extremes: max radius, full-scale axes, saturation
      csr_write(REG_RADIUS, 48'h7FFF_FFFF);
      csr_write(REG_X_AXIS, pack_axis(-32768, 32767, -32768));
      csr_write(REG_Y_AXIS, pack_axis(32767, -32768, 32767));
      csr_write(REG_Z_AXIS, pack_axis(32767, 32767, -32768));
      csr_write(REG_CENTER_X, 48'h7FFF_FFFF);
      csr_write(REG_CENTER_Y, 48'h8000_0000);
      random_phase(300);
      drain();

      // zero radius, random registers
      csr_write(REG_RADIUS, 48'd0);
      random_phase(50);
      drain();
      for (int i = 0; i < 7; i++) csr_write(3'(i), 48'({$urandom, $urandom} >> 16));
      csr_write(REG_RADIUS, {16'h0, 1'b0, 31'($urandom_range(0, 32'h00FF_FFFF))});
      random_phase(300);
      drain();

      $display("covered %0d vectors (%0d clipped) over five register settings,", rsp_count,
               clip_count);
      $display("with burst input, random output stalls and one long hold-off");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
design/ssd_pkg.sv
design/ssd_front.sv
design/ssd_queue.sv
design/ssd_back.sv
design/sphere_surface_point_and_derivative.sv
dv/sphere_eval_checker.sv
dv/sphere_surface_point_and_derivative_tb.sv
